### hdl/tccb_pkg.sv
// Shared types and constants for the text console cell buffer.
// No dependencies.
package tccb_pkg;

   localparam int CHAR_W = 21;
   localparam int ATTR_W = 50;
   localparam logic [CHAR_W-1:0] SPACE_CODE = 21'h20;

   localparam logic [3:0] OP_PUT_ADV  = 4'd0;
   localparam logic [3:0] OP_PUT_STAY = 4'd1;
   localparam logic [3:0] OP_NEWLINE  = 4'd2;
   localparam logic [3:0] OP_TAB      = 4'd3;
   localparam logic [3:0] OP_BACK     = 4'd4;
   localparam logic [3:0] OP_CLEAR    = 4'd5;
   localparam logic [3:0] OP_SET_CUR  = 4'd6;
   localparam logic [3:0] OP_SET_ATTR = 4'd7;
   localparam logic [3:0] OP_SET_VIS  = 4'd8;
   localparam logic [3:0] OP_READ     = 4'd9;

   localparam logic [1:0] CSR_COLUMNS = 2'd0;
   localparam logic [1:0] CSR_ROWS    = 2'd1;
   localparam logic [1:0] CSR_TAB     = 2'd2;

   typedef enum logic [4:0] {
      S_INIT, S_IDLE, S_TOPRED, S_DISPATCH, S_PUT_ADR, S_PUT_WR, S_SCROLL_CHK,
      S_ROW_ADR, S_ROW_WR, S_TAB_MOD, S_TAB_ADR, S_TAB_WR, S_TAB_NEXT,
      S_CLR_WR, S_RD_ADR, S_RD_MEM, S_RD_DATA, S_RESP_LOAD, S_RESP
   } state_type;

   typedef enum logic [2:0] {
      CUR_NONE, CUR_ADVANCE, CUR_NEWLINE, CUR_BACK, CUR_HOME, CUR_SET
   } cur_op_type;

   typedef enum logic [2:0] {
      AFF_HOLD, AFF_ONE, AFF_ROWS, AFF_LOAD_STEP, AFF_ADD_STEP, AFF_SAT
   } aff_op_type;

   typedef enum logic [1:0] {ADR_NONE, ADR_CUR, ADR_ARG, ADR_ROW0} adr_op_type;

   typedef enum logic [1:0] {WR_NONE, WR_CELL, WR_LIN, WR_INIT} wr_mode_type;

   typedef enum logic [1:0] {CH_INPUT, CH_SPACE, CH_ZERO} ch_sel_type;

   typedef struct packed {
      logic [CHAR_W-1:0] code;
      logic [ATTR_W-1:0] attr;
      logic              dirty;
   } cell_type;

   typedef struct packed {
      logic        latch;
      logic        top_red;
      logic        mod_init;
      logic        mod_step;
      logic        cnt_load;
      logic        cnt_dec;
      cur_op_type  cur_op;
      aff_op_type  aff_op;
      adr_op_type  adr_op;
      logic        acol_inc;
      wr_mode_type wr_mode;
      ch_sel_type  ch_sel;
      logic        rd_en;
      logic        lin_clr;
      logic        lin_inc;
      logic        set_attr;
      logic        set_vis;
      logic        rsp_load;
      logic        rsp_cell;
   } cmd_type;

   typedef struct packed {
      logic top_ge;
      logic mod_ge;
      logic cnt_zero;
      logic scrolled;
      logic col_last;
      logic lin_last;
      logic init_last;
      logic home;
      logic rd_ok;
   } status_type;

endpackage

### hdl/tccb_ctrl.sv
// Command sequencer for the console cell buffer.
// Depends on tccb_pkg; drives tccb_dp through cmd_type, reads status_type.
module tccb_ctrl import tccb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [3:0] req_opcode,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type  state_ff, state_in;
   logic [3:0] op_ff, op_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         op_ff    <= OP_PUT_ADV;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      case (state_ff)
         S_INIT:       if (status.init_last) state_in = S_IDLE;
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_opcode;
               state_in = S_TOPRED;
            end
         end
         S_TOPRED:     if (!status.top_ge) state_in = S_DISPATCH;
         S_DISPATCH: begin
            case (op_ff)
               OP_PUT_ADV, OP_PUT_STAY: state_in = S_PUT_ADR;
               OP_NEWLINE: state_in = S_SCROLL_CHK;
               OP_TAB:     state_in = S_TAB_MOD;
               OP_BACK:    state_in = status.home ? S_RESP_LOAD : S_PUT_ADR;
               OP_CLEAR:   state_in = S_CLR_WR;
               OP_READ:    state_in = status.rd_ok ? S_RD_ADR : S_RESP_LOAD;
               default:    state_in = S_RESP_LOAD;
            endcase
         end
         S_PUT_ADR:    state_in = S_PUT_WR;
         S_PUT_WR:     state_in = (op_ff == OP_PUT_ADV) ? S_SCROLL_CHK : S_RESP_LOAD;
         S_SCROLL_CHK: begin
            if (status.scrolled) state_in = S_ROW_ADR;
            else state_in = (op_ff == OP_TAB) ? S_TAB_NEXT : S_RESP_LOAD;
         end
         S_ROW_ADR:    state_in = S_ROW_WR;
         S_ROW_WR: begin
            if (status.col_last) state_in = (op_ff == OP_TAB) ? S_TAB_NEXT : S_RESP_LOAD;
         end
         S_TAB_MOD:    if (!status.mod_ge) state_in = S_TAB_ADR;
         S_TAB_ADR:    state_in = S_TAB_WR;
         S_TAB_WR:     state_in = S_SCROLL_CHK;
         S_TAB_NEXT:   state_in = status.cnt_zero ? S_RESP_LOAD : S_TAB_ADR;
         S_CLR_WR:     if (status.lin_last) state_in = S_RESP_LOAD;
         S_RD_ADR:     state_in = S_RD_MEM;
         S_RD_MEM:     state_in = S_RD_DATA;
         S_RD_DATA:    state_in = S_RESP;
         S_RESP_LOAD:  state_in = S_RESP;
         S_RESP:       if (rsp_ready) state_in = S_IDLE;
         default:      state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         S_INIT: begin
            cmd.wr_mode = WR_INIT;
            cmd.lin_inc = 1'b1;
            cmd.lin_clr = status.init_last;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.latch = req_valid;
         end
         S_TOPRED: cmd.top_red = status.top_ge;
         S_DISPATCH: begin
            case (op_ff)
               OP_NEWLINE: begin
                  cmd.cur_op = CUR_NEWLINE;
                  cmd.aff_op = AFF_LOAD_STEP;
               end
               OP_TAB: begin
                  cmd.mod_init = 1'b1;
                  cmd.aff_op   = AFF_ONE;
               end
               OP_BACK: begin
                  if (!status.home) begin
                     cmd.cur_op = CUR_BACK;
                     cmd.aff_op = AFF_LOAD_STEP;
                  end
               end
               OP_CLEAR:    cmd.lin_clr  = 1'b1;
               OP_SET_CUR:  cmd.cur_op   = CUR_SET;
               OP_SET_ATTR: cmd.set_attr = 1'b1;
               OP_SET_VIS:  cmd.set_vis  = 1'b1;
               default: ;
            endcase
         end
         S_PUT_ADR: cmd.adr_op = ADR_CUR;
         S_PUT_WR: begin
            cmd.wr_mode = WR_CELL;
            cmd.ch_sel  = (op_ff == OP_BACK) ? CH_SPACE : CH_INPUT;
            if (op_ff == OP_PUT_ADV) begin
               cmd.cur_op = CUR_ADVANCE;
               cmd.aff_op = AFF_LOAD_STEP;
            end else if (op_ff == OP_PUT_STAY) begin
               cmd.aff_op = AFF_LOAD_STEP;
            end
         end
         S_ROW_ADR: cmd.adr_op = ADR_ROW0;
         S_ROW_WR: begin
            cmd.wr_mode  = WR_CELL;
            cmd.ch_sel   = CH_ZERO;
            cmd.acol_inc = 1'b1;
         end
         S_TAB_MOD: begin
            cmd.mod_step = status.mod_ge;
            cmd.cnt_load = !status.mod_ge;
         end
         S_TAB_ADR: cmd.adr_op = ADR_CUR;
         S_TAB_WR: begin
            cmd.wr_mode = WR_CELL;
            cmd.ch_sel  = CH_SPACE;
            cmd.cur_op  = CUR_ADVANCE;
            cmd.aff_op  = AFF_ADD_STEP;
            cmd.cnt_dec = 1'b1;
         end
         S_TAB_NEXT: if (status.cnt_zero) cmd.aff_op = AFF_SAT;
         S_CLR_WR: begin
            cmd.wr_mode = WR_LIN;
            cmd.lin_inc = 1'b1;
            if (status.lin_last) begin
               cmd.cur_op  = CUR_HOME;
               cmd.aff_op  = AFF_ROWS;
               cmd.lin_clr = 1'b1;
            end
         end
         S_RD_ADR: cmd.adr_op = ADR_ARG;
         S_RD_MEM: cmd.rd_en = 1'b1;
         S_RD_DATA: begin
            cmd.rsp_load = 1'b1;
            cmd.rsp_cell = 1'b1;
         end
         S_RESP_LOAD: cmd.rsp_load = 1'b1;
         S_RESP: rsp_valid = 1'b1;
         default: ;
      endcase
   end

endmodule

### hdl/tccb_dp.sv
// Datapath of the console cell buffer: config, cursor, counters, cell memory, result.
// Depends on tccb_pkg; commanded by tccb_ctrl.
module tccb_dp import tccb_pkg::*; #(
   parameter int MAX_COLS = 128,
   parameter int MAX_ROWS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [7:0]        csr_wdata,
   input  logic [20:0]       req_char_code,
   input  logic [6:0]        req_col_arg,
   input  logic [5:0]        req_row_arg,
   input  logic [49:0]       req_attr_word,
   input  logic              req_visible_arg,
   input  cmd_type           cmd,
   output status_type        status,
   output logic [6:0]        rsp_rows_affected,
   output logic [6:0]        rsp_cursor_col,
   output logic [5:0]        rsp_cursor_row,
   output logic [5:0]        rsp_scroll_top,
   output logic [20:0]       rsp_cell_char,
   output logic [49:0]       rsp_cell_attr,
   output logic              rsp_cell_dirty,
   output logic              rsp_cursor_here,
   output logic              rsp_bad_position
);

   localparam int DEPTH = MAX_COLS * MAX_ROWS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CNW   = $clog2(MAX_COLS + 1);
   localparam int RNW   = $clog2(MAX_ROWS + 1);
   localparam int LW    = $clog2(DEPTH + 1);
   localparam int AFW   = $clog2(16 * MAX_ROWS + 1);

   logic [7:0] cols_cfg_ff;
   logic [6:0] rows_cfg_ff;
   logic [4:0] tab_cfg_ff;

   logic [CNW-1:0] cols;
   logic [RNW-1:0] rows;
   logic [4:0]     tab;

   logic [CW-1:0]     cur_col_ff, cur_col_in;
   logic [RW-1:0]     cur_row_ff, cur_row_in;
   logic [RW-1:0]     top_ff, top_in;
   logic [RW-1:0]     topm_ff, topm_in;
   logic [ATTR_W-1:0] active_attr_ff;
   logic              show_ff;
   logic [CHAR_W-1:0] char_ff;
   logic [6:0]        ca_ff;
   logic [5:0]        ra_ff;
   logic [ATTR_W-1:0] attr_ff;
   logic              vis_ff;
   logic              bad_ff, bad_in;
   logic              scrolled_ff, scrolled_in;
   logic [CW-1:0]     modv_ff;
   logic [4:0]        cnt_ff;
   logic [AFW-1:0]    aff_ff;
   logic [LW-1:0]     limit_ff;
   logic [AW-1:0]     lin_ff;
   logic [RW-1:0]     phys_ff;
   logic [CW-1:0]     acol_ff;
   cell_type          rd_ff;

   cell_type          cell_mem [DEPTH];

   logic [CW:0]    c1;
   logic [RW:0]    r1, t1, s;
   logic           wrap, scroll;
   logic [AFW-1:0] step_r;
   logic [RW-1:0]  src_row, topn;
   logic [LW:0]    addr_full;
   logic [AW-1:0]  addr;
   cell_type       wr_cell;

   always_comb begin
      if (cols_cfg_ff == 8'd0) cols = CNW'(1);
      else if (cols_cfg_ff > MAX_COLS) cols = CNW'(MAX_COLS);
      else cols = CNW'(cols_cfg_ff);
      if (rows_cfg_ff == 7'd0) rows = RNW'(1);
      else if (rows_cfg_ff > MAX_ROWS) rows = RNW'(MAX_ROWS);
      else rows = RNW'(rows_cfg_ff);
      if (tab_cfg_ff == 5'd0) tab = 5'd1;
      else if (tab_cfg_ff > 5'd16) tab = 5'd16;
      else tab = tab_cfg_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_cfg_ff <= 8'd80;
         rows_cfg_ff <= 7'd25;
         tab_cfg_ff  <= 5'd8;
      end else if (csr_we) begin
         case (csr_index)
            CSR_COLUMNS: cols_cfg_ff <= csr_wdata;
            CSR_ROWS:    rows_cfg_ff <= csr_wdata[6:0];
            CSR_TAB:     tab_cfg_ff  <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   // cursor step
   always_comb begin
      cur_col_in  = cur_col_ff;
      cur_row_in  = cur_row_ff;
      top_in      = top_ff;
      topm_in     = topm_ff;
      bad_in      = bad_ff;
      wrap        = 1'b0;
      scroll      = 1'b0;
      c1          = (CW+1)'(cur_col_ff) + (CW+1)'(1);
      r1          = (RW+1)'(cur_row_ff) + (RW+1)'(1);
      t1          = (RW+1)'(topm_ff) + (RW+1)'(1);
      topn        = (t1 == (RW+1)'(rows)) ? '0 : RW'(t1);
      step_r      = AFW'(1);
      case (cmd.cur_op)
         CUR_ADVANCE, CUR_NEWLINE: begin
            if (cmd.cur_op == CUR_NEWLINE || c1 >= (CW+1)'(cols)) begin
               wrap       = 1'b1;
               cur_col_in = '0;
               if (r1 >= (RW+1)'(rows)) begin
                  scroll     = 1'b1;
                  cur_row_in = RW'(rows - RNW'(1));
                  top_in     = topn;
                  topm_in    = topn;
               end else begin
                  cur_row_in = RW'(r1);
               end
            end else begin
               cur_col_in = CW'(c1);
            end
            step_r = scroll ? AFW'(rows) : (wrap ? AFW'(2) : AFW'(1));
         end
         CUR_BACK: begin
            if (cur_col_ff == '0) begin
               cur_col_in = CW'(cols - CNW'(1));
               cur_row_in = cur_row_ff - RW'(1);
               step_r     = AFW'(2);
            end else begin
               cur_col_in = cur_col_ff - CW'(1);
            end
         end
         CUR_HOME: begin
            cur_col_in = '0;
            cur_row_in = '0;
         end
         CUR_SET: begin
            if (ca_ff >= cols || ra_ff >= rows) begin
               bad_in = 1'b1;
            end else begin
               cur_col_in = CW'(ca_ff);
               cur_row_in = RW'(ra_ff);
            end
         end
         default: ;
      endcase
      if (cmd.latch) begin
         cur_col_in = (cur_col_ff >= cols) ? CW'(cols - CNW'(1)) : cur_col_ff;
         cur_row_in = (cur_row_ff >= rows) ? RW'(rows - RNW'(1)) : cur_row_ff;
         topm_in    = top_ff;
         bad_in     = 1'b0;
      end else if (cmd.top_red) begin
         topm_in = RW'(topm_ff - rows);
      end
      scrolled_in = scroll;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_col_ff     <= '0;
         cur_row_ff     <= '0;
         top_ff         <= '0;
         topm_ff        <= '0;
         active_attr_ff <= '0;
         show_ff        <= 1'b0;
         bad_ff         <= 1'b0;
         scrolled_ff    <= 1'b0;
         lin_ff         <= '0;
      end else begin
         cur_col_ff  <= cur_col_in;
         cur_row_ff  <= cur_row_in;
         top_ff      <= top_in;
         topm_ff     <= topm_in;
         bad_ff      <= bad_in;
         scrolled_ff <= scrolled_in;
         if (cmd.set_attr) active_attr_ff <= attr_ff;
         if (cmd.set_vis) show_ff <= vis_ff;
         if (cmd.lin_clr) lin_ff <= '0;
         else if (cmd.lin_inc) lin_ff <= lin_ff + AW'(1);
      end
   end

   // held item fields, counters, address
   always_comb begin
      src_row   = (cmd.adr_op == ADR_ARG) ? RW'(ra_ff) : cur_row_ff;
      s         = (RW+1)'(src_row) + (RW+1)'(topm_ff);
      addr_full = (LW+1)'(phys_ff) * (LW+1)'(cols) + (LW+1)'(acol_ff);
      addr      = (cmd.wr_mode == WR_LIN || cmd.wr_mode == WR_INIT) ? lin_ff : AW'(addr_full);
      wr_cell.dirty = 1'b1;
      wr_cell.attr  = (cmd.wr_mode == WR_INIT) ? '0 : active_attr_ff;
      case (cmd.ch_sel)
         CH_INPUT: wr_cell.code = char_ff;
         CH_SPACE: wr_cell.code = SPACE_CODE;
         default:  wr_cell.code = '0;
      endcase
      if (cmd.wr_mode == WR_LIN || cmd.wr_mode == WR_INIT) wr_cell.code = '0;
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         char_ff  <= req_char_code;
         ca_ff    <= req_col_arg;
         ra_ff    <= req_row_arg;
         attr_ff  <= req_attr_word;
         vis_ff   <= req_visible_arg;
         limit_ff <= LW'(LW'(cols) * LW'(rows));
         aff_ff   <= '0;
      end
      if (cmd.mod_init) modv_ff <= cur_col_ff;
      else if (cmd.mod_step) modv_ff <= CW'(modv_ff - tab);
      if (cmd.cnt_load) cnt_ff <= tab - 5'(modv_ff);
      else if (cmd.cnt_dec) cnt_ff <= cnt_ff - 5'd1;
      case (cmd.aff_op)
         AFF_ONE:       aff_ff <= AFW'(1);
         AFF_ROWS:      aff_ff <= AFW'(rows);
         AFF_LOAD_STEP: aff_ff <= step_r;
         AFF_ADD_STEP:  aff_ff <= aff_ff + step_r - AFW'(1);
         AFF_SAT:       if (aff_ff > AFW'(rows)) aff_ff <= AFW'(rows);
         default: ;
      endcase
      if (cmd.adr_op != ADR_NONE) begin
         phys_ff <= (s >= (RW+1)'(rows)) ? RW'(s - (RW+1)'(rows)) : RW'(s);
         case (cmd.adr_op)
            ADR_CUR: acol_ff <= cur_col_ff;
            ADR_ARG: acol_ff <= CW'(ca_ff);
            default: acol_ff <= '0;
         endcase
      end else if (cmd.acol_inc) begin
         acol_ff <= acol_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_mode != WR_NONE) cell_mem[addr] <= wr_cell;
      if (cmd.rd_en) rd_ff <= cell_mem[addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_rows_affected <= 7'(aff_ff);
         rsp_cursor_col    <= 7'(cur_col_ff);
         rsp_cursor_row    <= 6'(cur_row_ff);
         rsp_scroll_top    <= 6'(top_ff);
         rsp_bad_position  <= bad_ff;
         rsp_cell_char     <= cmd.rsp_cell ? rd_ff.code : '0;
         rsp_cell_attr     <= cmd.rsp_cell ? rd_ff.attr : '0;
         rsp_cell_dirty    <= cmd.rsp_cell & rd_ff.dirty;
         rsp_cursor_here   <= cmd.rsp_cell & show_ff & (7'(cur_col_ff) == ca_ff)
                              & (6'(cur_row_ff) == ra_ff);
      end
   end

   always_comb begin
      status.top_ge    = (topm_ff >= rows);
      status.mod_ge    = (modv_ff >= tab);
      status.cnt_zero  = (cnt_ff == 5'd0);
      status.scrolled  = scrolled_ff;
      status.col_last  = ((CNW+1)'(acol_ff) + (CNW+1)'(1) == (CNW+1)'(cols));
      status.lin_last  = ((LW+1)'(lin_ff) + (LW+1)'(1) == (LW+1)'(limit_ff));
      status.init_last = (lin_ff == AW'(DEPTH - 1));
      status.home      = (cur_col_ff == '0) && (cur_row_ff == '0);
      status.rd_ok     = (ca_ff < cols) && (ra_ff < rows);
   end

endmodule

### hdl/text_console_cell_buffer_unit.sv
// Top level of the text console cell buffer: sequencer plus datapath.
// Depends on tccb_pkg, tccb_ctrl and tccb_dp.
//
//   channel | ports  | direction | handshake
//   request | req_*  | in        | req_valid / req_ready
//   result  | rsp_*  | out       | rsp_valid / rsp_ready
//   config  | csr_*  | in        | csr_we, no wait
//
// An item passes through latch, dispatch and its command states, then the result
// handoff. Each cell write takes a turn on the single memory port: a scroll zeroes
// every column of the new bottom row, a tab reduces the cursor column modulo the tab
// width and writes at most 16 spaces, and clear writes columns * rows cells.
// After a rows change, a stale top pointer is reduced step by step before dispatch.
// After reset a clearing pass over all MAX_COLS * MAX_ROWS cells runs before req_ready.
// A stalled result holds the block until rsp_ready.
module text_console_cell_buffer_unit import tccb_pkg::*; #(
   parameter int MAX_COLS = 128,
   parameter int MAX_ROWS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_opcode,
   input  logic [20:0] req_char_code,
   input  logic [6:0]  req_col_arg,
   input  logic [5:0]  req_row_arg,
   input  logic [49:0] req_attr_word,
   input  logic        req_visible_arg,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [6:0]  rsp_rows_affected,
   output logic [6:0]  rsp_cursor_col,
   output logic [5:0]  rsp_cursor_row,
   output logic [5:0]  rsp_scroll_top,
   output logic [20:0] rsp_cell_char,
   output logic [49:0] rsp_cell_attr,
   output logic        rsp_cell_dirty,
   output logic        rsp_cursor_here,
   output logic        rsp_bad_position,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   cmd_type    cmd;
   status_type status;

   tccb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_opcode(req_opcode),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tccb_dp #(
      .MAX_COLS(MAX_COLS),
      .MAX_ROWS(MAX_ROWS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_char_code    (req_char_code),
      .req_col_arg      (req_col_arg),
      .req_row_arg      (req_row_arg),
      .req_attr_word    (req_attr_word),
      .req_visible_arg  (req_visible_arg),
      .cmd              (cmd),
      .status           (status),
      .rsp_rows_affected(rsp_rows_affected),
      .rsp_cursor_col   (rsp_cursor_col),
      .rsp_cursor_row   (rsp_cursor_row),
      .rsp_scroll_top   (rsp_scroll_top),
      .rsp_cell_char    (rsp_cell_char),
      .rsp_cell_attr    (rsp_cell_attr),
      .rsp_cell_dirty   (rsp_cell_dirty),
      .rsp_cursor_here  (rsp_cursor_here),
      .rsp_bad_position (rsp_bad_position)
   );

endmodule

### bench/testbench.sv
// Self-checking bench for text_console_cell_buffer_unit: a local console
// model predicts each result. Depends on tccb_pkg and the RTL top level.
`timescale 1ns / 100ps

module testbench;
   import tccb_pkg::*;

   localparam int NCOLS = 128;
   localparam int NROWS = 64;
   localparam int NCELLS = NCOLS * NROWS;
   localparam int IDLE_LIMIT = 200000;

   typedef struct packed {
      logic [3:0]  opcode;
      logic [20:0] char_code;
      logic [6:0]  col_arg;
      logic [5:0]  row_arg;
      logic [49:0] attr_word;
      logic        visible_arg;
   } cmd_item_type;

   typedef struct packed {
      logic [6:0]  rows_affected;
      logic [6:0]  cursor_col;
      logic [5:0]  cursor_row;
      logic [5:0]  scroll_top;
      logic [20:0] cell_char;
      logic [49:0] cell_attr;
      logic        cell_dirty;
      logic        cursor_here;
      logic        bad_position;
   } console_result_type;

   logic clock, reset;
   logic req_valid, req_ready;
   logic [3:0] req_opcode;
   logic [20:0] req_char_code;
   logic [6:0] req_col_arg;
   logic [5:0] req_row_arg;
   logic [49:0] req_attr_word;
   logic req_visible_arg;
   logic rsp_valid, rsp_ready;
   logic [6:0] rsp_rows_affected, rsp_cursor_col;
   logic [5:0] rsp_cursor_row, rsp_scroll_top;
   logic [20:0] rsp_cell_char;
   logic [49:0] rsp_cell_attr;
   logic rsp_cell_dirty, rsp_cursor_here, rsp_bad_position;
   logic csr_we;
   logic [1:0] csr_index;
   logic [7:0] csr_wdata;

   text_console_cell_buffer_unit DUT (.*);

   // console model state
   int unsigned m_cols_reg, m_rows_reg, m_tab_reg;
   int unsigned m_col, m_row, m_top;
   logic [49:0] m_attr;
   logic m_show;
   logic [20:0] m_code [NCELLS];
   logic [49:0] m_cattr [NCELLS];
   logic m_dirty [NCELLS];

   cmd_item_type pending_cmds[$];
   console_result_type expected_results[$];
   int errors, mismatches, idle_cycles;

   bit rsp_hold_req;
   int rsp_hold_cycles;
   bit driver_enable;

   function automatic int unsigned cols_eff();
      if (m_cols_reg == 0) return 1;
      return m_cols_reg > NCOLS ? NCOLS : m_cols_reg;
   endfunction

   function automatic int unsigned rows_eff();
      if (m_rows_reg == 0) return 1;
      return m_rows_reg > NROWS ? NROWS : m_rows_reg;
   endfunction

   function automatic int unsigned tab_eff();
      if (m_tab_reg == 0) return 1;
      return m_tab_reg > 16 ? 16 : m_tab_reg;
   endfunction

   function automatic int unsigned cell_at(int unsigned c, int unsigned r);
      return (((r + m_top) % rows_eff()) * cols_eff() + c) % NCELLS;
   endfunction

   function automatic void store_cell(int unsigned c, int unsigned r, logic [20:0] ch);
      int unsigned i;
      i = cell_at(c, r);
      m_code[i] = ch;
      m_cattr[i] = m_attr;
      m_dirty[i] = 1'b1;
   endfunction

   function automatic int unsigned line_feed();
      int unsigned c;
      if (m_row >= rows_eff()) begin
         m_row = rows_eff() - 1;
         m_top = (m_top + 1) % rows_eff();
         for (c = 0; c < cols_eff(); c++) store_cell(c, m_row, '0);
         return rows_eff();
      end
      return 2;
   endfunction

   function automatic int unsigned put_cell(logic [20:0] ch, bit adv);
      store_cell(m_col, m_row, ch);
      if (!adv) return 1;
      m_col++;
      if (m_col >= cols_eff()) begin
         m_col = 0;
         m_row++;
         return line_feed();
      end
      return 1;
   endfunction

   function automatic console_result_type apply_command(cmd_item_type it);
      console_result_type res;
      int unsigned cols, rows, aff, n, k, idx;
      res = '0;
      cols = cols_eff();
      rows = rows_eff();
      aff = 0;
      if (m_col >= cols) m_col = cols - 1;
      if (m_row >= rows) m_row = rows - 1;
      case (it.opcode)
         OP_PUT_ADV: aff = put_cell(it.char_code, 1);
         OP_PUT_STAY: aff = put_cell(it.char_code, 0);
         OP_NEWLINE: begin
            m_col = 0;
            m_row++;
            aff = line_feed();
         end
         OP_TAB: begin
            n = tab_eff() - (m_col % tab_eff());
            aff = 1;
            for (k = 0; k < n; k++) aff += put_cell(SPACE_CODE, 1) - 1;
            if (aff > rows) aff = rows;
         end
         OP_BACK: begin
            if (m_col == 0 && m_row == 0) aff = 0;
            else if (m_col == 0) begin
               m_col = cols - 1;
               m_row--;
               void'(put_cell(SPACE_CODE, 0));
               aff = 2;
            end else begin
               m_col--;
               void'(put_cell(SPACE_CODE, 0));
               aff = 1;
            end
         end
         OP_CLEAR: begin
            for (k = 0; k < cols * rows && k < NCELLS; k++) begin
               m_code[k] = '0;
               m_cattr[k] = m_attr;
               m_dirty[k] = 1'b1;
            end
            m_col = 0;
            m_row = 0;
            aff = rows;
         end
         OP_SET_CUR: begin
            if (it.col_arg >= cols || it.row_arg >= rows) res.bad_position = 1'b1;
            else begin
               m_col = it.col_arg;
               m_row = it.row_arg;
            end
         end
         OP_SET_ATTR: m_attr = it.attr_word;
         OP_SET_VIS: m_show = it.visible_arg;
         OP_READ: begin
            if (it.col_arg < cols && it.row_arg < rows) begin
               idx = cell_at(it.col_arg, it.row_arg);
               res.cell_char = m_code[idx];
               res.cell_attr = m_cattr[idx];
               res.cell_dirty = m_dirty[idx];
               res.cursor_here = m_show && m_col == it.col_arg && m_row == it.row_arg;
            end
         end
         default: ;
      endcase
      res.rows_affected = aff[6:0];
      res.cursor_col = m_col[6:0];
      res.cursor_row = m_row[5:0];
      res.scroll_top = m_top[5:0];
      return res;
   endfunction

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid && req_ready)
            expected_results.push_back(apply_command(pending_cmds.pop_front()));
         if (driver_enable && pending_cmds.size() > 0 &&
             (pending_cmds.size() != pending_cmds.size() || $urandom_range(0, 99) < 70 ||
              rsp_hold_cycles > 0)) begin
            req_valid <= 1'b1;
            {req_opcode, req_char_code, req_col_arg, req_row_arg, req_attr_word,
             req_visible_arg} <= pending_cmds[0];
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold_cycles <= 0;
      end else if (rsp_hold_req && rsp_hold_cycles == 0) begin
         rsp_hold_cycles <= 400;
         rsp_ready <= 1'b0;
      end else if (rsp_hold_cycles > 0) begin
         rsp_hold_cycles <= rsp_hold_cycles - 1;
         rsp_ready <= (rsp_hold_cycles == 1);
      end else begin
         case ($urandom_range(0, 19))
            0: rsp_ready <= 1'b0;
            1, 2: rsp_ready <= 1'($urandom_range(0, 1));
            default: rsp_ready <= 1'b1;
         endcase
      end
   end

   // monitor
   always @(posedge clock) begin
      console_result_type got, want;
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp_valid && rsp_ready) begin
            got = {rsp_rows_affected, rsp_cursor_col, rsp_cursor_row, rsp_scroll_top,
                   rsp_cell_char, rsp_cell_attr, rsp_cell_dirty, rsp_cursor_here,
                   rsp_bad_position};
            if (expected_results.size() == 0) begin
               errors++;
               if (mismatches++ < 10) $display("unexpected item: %p", got);
            end else begin
               want = expected_results.pop_front();
               if (got !== want) begin
                  errors++;
                  if (mismatches++ < 10) $display("mismatch: expected %p actual %p", want, got);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && idle_cycles >= IDLE_LIMIT) begin
         $display("text_console_cell_buffer_unit verification failed");
         $finish;
      end
   end

   task automatic write_csr(logic [1:0] idx, logic [7:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_COLUMNS: m_cols_reg = val;
         CSR_ROWS: m_rows_reg = val[6:0];
         default: m_tab_reg = val[4:0];
      endcase
   endtask

   task automatic drain();
      while (pending_cmds.size() > 0 || req_valid || expected_results.size() > 0)
         @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   function automatic cmd_item_type make_cmd(logic [3:0] op);
      cmd_item_type it;
      it.opcode = op;
      it.char_code = 21'($urandom_range(0, 1114111));
      it.col_arg = $urandom_range(0, 3) == 0 ? 7'($urandom_range(0, 127)) :
                   7'($urandom_range(0, cols_eff() > 0 ? cols_eff() - 1 : 0));
      it.row_arg = $urandom_range(0, 3) == 0 ? 6'($urandom_range(0, 63)) :
                   6'($urandom_range(0, rows_eff() - 1));
      it.attr_word = {2'($urandom_range(0, 3)), $urandom(), 16'($urandom())};
      it.visible_arg = 1'($urandom_range(0, 1));
      return it;
   endfunction

   function automatic logic [3:0] pick_op();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 35) return OP_PUT_ADV;
      if (r < 42) return OP_PUT_STAY;
      if (r < 52) return OP_NEWLINE;
      if (r < 58) return OP_TAB;
      if (r < 64) return OP_BACK;
      if (r < 65) return OP_CLEAR;
      if (r < 73) return OP_SET_CUR;
      if (r < 78) return OP_SET_ATTR;
      if (r < 82) return OP_SET_VIS;
      if (r < 97) return OP_READ;
      return 4'($urandom_range(10, 15));
   endfunction

   task automatic random_phase(int count);
      for (int k = 0; k < count; k++) pending_cmds.push_back(make_cmd(pick_op()));
   endtask

   initial begin
      cmd_item_type it;
      int unsigned c;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_COLUMNS;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_opcode = OP_PUT_ADV;
      req_char_code = '0;
      req_col_arg = '0;
      req_row_arg = '0;
      req_attr_word = '0;
      req_visible_arg = 1'b0;
      rsp_hold_req = 1'b0;
      driver_enable = 1'b1;
      errors = 0;
      mismatches = 0;
      idle_cycles = 0;
      m_cols_reg = 80; m_rows_reg = 25; m_tab_reg = 8;
      m_col = 0; m_row = 0; m_top = 0; m_attr = '0; m_show = 1'b0;
      for (c = 0; c < NCELLS; c++) begin
         m_code[c] = '0; m_cattr[c] = '0; m_dirty[c] = 1'b1;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // small screen for directed checks
      write_csr(CSR_COLUMNS, 8'd4);
      write_csr(CSR_ROWS, 8'd3);
      write_csr(CSR_TAB, 8'd3);
      it = make_cmd(OP_BACK); pending_cmds.push_back(it);
      it = make_cmd(OP_SET_VIS); it.visible_arg = 1; pending_cmds.push_back(it);
      it = make_cmd(OP_SET_ATTR); it.attr_word = '1; pending_cmds.push_back(it);
      it = make_cmd(OP_PUT_ADV); it.char_code = 21'h10FFFF; pending_cmds.push_back(it);
      it = make_cmd(OP_PUT_STAY); it.char_code = '0; pending_cmds.push_back(it);
      it = make_cmd(OP_TAB); pending_cmds.push_back(it);
      it = make_cmd(OP_BACK); pending_cmds.push_back(it);
      it = make_cmd(OP_NEWLINE); pending_cmds.push_back(it);
      it = make_cmd(OP_NEWLINE); pending_cmds.push_back(it);
      it = make_cmd(OP_NEWLINE); pending_cmds.push_back(it);
      it = make_cmd(OP_SET_CUR); it.col_arg = 127; it.row_arg = 0; pending_cmds.push_back(it);
      it = make_cmd(OP_SET_CUR); it.col_arg = 0; it.row_arg = 63; pending_cmds.push_back(it);
      it = make_cmd(OP_SET_CUR); it.col_arg = 3; it.row_arg = 2; pending_cmds.push_back(it);
      it = make_cmd(OP_PUT_ADV); pending_cmds.push_back(it);
      it = make_cmd(OP_READ); it.col_arg = 0; it.row_arg = 0; pending_cmds.push_back(it);
      it = make_cmd(OP_READ); it.col_arg = 3; it.row_arg = 2; pending_cmds.push_back(it);
      it = make_cmd(OP_READ); it.col_arg = 127; it.row_arg = 63; pending_cmds.push_back(it);
      it = make_cmd(OP_SET_ATTR); it.attr_word = '0; pending_cmds.push_back(it);
      it = make_cmd(OP_CLEAR); pending_cmds.push_back(it);
      it = make_cmd(4'd15); it.char_code = '1; it.col_arg = '1; it.row_arg = '1;
      pending_cmds.push_back(it);
      drain();

      // tab wide enough to scroll several times on a tiny screen
      write_csr(CSR_COLUMNS, 8'd1);
      write_csr(CSR_ROWS, 8'd1);
      write_csr(CSR_TAB, 8'd16);
      random_phase(120);
      drain();

      write_csr(CSR_COLUMNS, 8'd0);
      write_csr(CSR_ROWS, 8'd0);
      write_csr(CSR_TAB, 8'd0);
      random_phase(100);
      drain();

      write_csr(CSR_COLUMNS, 8'd7);
      write_csr(CSR_ROWS, 8'd5);
      write_csr(CSR_TAB, 8'd5);
      random_phase(400);
      rsp_hold_req <= 1'b1;
      @(posedge clock);
      rsp_hold_req <= 1'b0;
      drain();

      // rows shrink under a stale top pointer
      write_csr(CSR_ROWS, 8'd3);
      write_csr(CSR_TAB, 8'd31);
      random_phase(300);
      drain();

      write_csr(CSR_COLUMNS, 8'd255);
      write_csr(CSR_ROWS, 8'd127);
      write_csr(CSR_TAB, 8'd2);
      random_phase(150);
      drain();

      write_csr(CSR_COLUMNS, 8'd128);
      write_csr(CSR_ROWS, 8'd64);
      write_csr(CSR_TAB, 8'd16);
      random_phase(60);
      drain();

      write_csr(CSR_COLUMNS, 8'd13);
      write_csr(CSR_ROWS, 8'd6);
      write_csr(CSR_TAB, 8'd4);
      random_phase(350);
      drain();

      if (errors == 0) $display("text_console_cell_buffer_unit verification clean");
      else $display("text_console_cell_buffer_unit verification failed");
      $finish;
   end
endmodule

### text_console_cell_buffer_unit.f
hdl/tccb_pkg.sv
hdl/tccb_ctrl.sv
hdl/tccb_dp.sv
hdl/text_console_cell_buffer_unit.sv
bench/testbench.sv
